// File: design/otsb_pkg.sv
// Package: shared constants and types for the one-shot timer slot bank.
package otsb_pkg;

  // Bank size; slot fields are three bits, so at most eight slots exist
  localparam int SLOT_COUNT = 8;
  localparam int HW_SLOTS   = 8;
  localparam int EFF_SLOTS  = (SLOT_COUNT < HW_SLOTS) ? SLOT_COUNT : HW_SLOTS;

  // Field widths
  localparam int OP_W   = 2;
  localparam int SLOT_W = 3;
  localparam int MS_W   = 32;
  localparam int KIND_W = 3;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    K_STARTED   = 3'd0,
    K_FULL      = 3'd1,
    K_CANCELLED = 3'd2,
    K_QUERY     = 3'd3,
    K_EXPIRED   = 3'd4
  } kind_t;

  typedef enum logic {
    BK_RUN  = 1'b0,
    BK_EMIT = 1'b1
  } bk_state_t;

  // Classified request as held in the queue
  typedef struct packed {
    op_t               op;
    logic [MS_W-1:0]   period;   // already clamped to at least one tick
    logic [SLOT_W-1:0] idx;
    logic              in_range; // idx addresses an existing slot
    logic              arm;
  } cmd_t;

  // One result item
  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [MS_W-1:0]   remaining;
    logic              running;
    logic              last;
  } res_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// File: design/otsb_if.sv
// Interfaces: request channel and result channel of the timer slot bank.
interface otsb_in_if import otsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [MS_W-1:0]   period_ms;
  logic [SLOT_W-1:0] slot_index;
  logic              arm_notify;

  modport source (output valid, opcode, period_ms, slot_index, arm_notify, input ready);
  modport sink   (input valid, opcode, period_ms, slot_index, arm_notify, output ready);
endinterface

interface otsb_out_if import otsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot_number;
  logic [MS_W-1:0]   remaining_ms;
  logic              is_running;
  logic              last_of_run;

  modport source (output valid, kind, slot_number, remaining_ms, is_running, last_of_run,
                  input ready);
  modport sink   (input valid, kind, slot_number, remaining_ms, is_running, last_of_run,
                  output ready);
endinterface

// File: design/one_shot_timer_slot_bank_top.sv
// Top level: one-shot millisecond timer slot bank.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+----------------------------------------------
//   in_chan  | in  | valid/ready   | opcode, period_ms, slot_index, arm_notify
//   out_chan | out | valid/ready   | kind, slot_number, remaining_ms, is_running,
//            |     |               | last_of_run
//
// A request enters a two-entry command queue and leaves it in the next cycle at
// the earliest; start, cancel and query each run once the result register is free
// and give their result in the following cycle. A tick counts every active slot
// down even while the result stalls, then the notified expiries go out one by one.
// Reset clears all slots, the queue pointers and the result valid flag. A stalled
// result holds the other commands; requests keep entering until the queue fills.
module one_shot_timer_slot_bank_top import otsb_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  otsb_in_if.sink           in_chan,
  otsb_out_if.source        out_chan
);

  logic    push;
  cmd_t    push_cmd;
  logic    q_full;
  logic    pop;
  q_head_t head;
  res_t    res;

  otsb_front u_front (
    .in_valid      (in_chan.valid),
    .in_ready      (in_chan.ready),
    .in_opcode     (in_chan.opcode),
    .in_period_ms  (in_chan.period_ms),
    .in_slot_index (in_chan.slot_index),
    .in_arm_notify (in_chan.arm_notify),
    .push          (push),
    .push_cmd      (push_cmd),
    .q_full        (q_full)
  );

  otsb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  otsb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (res)
  );

  // Result fields onto the channel
  assign out_chan.kind         = res.kind;
  assign out_chan.slot_number  = res.slot;
  assign out_chan.remaining_ms = res.remaining;
  assign out_chan.is_running   = res.running;
  assign out_chan.last_of_run  = res.last;

endmodule

// File: design/otsb_front.sv
// Front end: decodes and classifies incoming requests for the command queue.
module otsb_front import otsb_pkg::*; (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [MS_W-1:0]   in_period_ms,
  input  logic [SLOT_W-1:0] in_slot_index,
  input  logic              in_arm_notify,
  output logic              push,
  output cmd_t              push_cmd,
  input  logic              q_full
);

  // Accept whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Classify: opcode, clamped period, slot range check
  always_comb begin
    push_cmd.op       = op_t'(in_opcode);
    push_cmd.period   = (in_period_ms == '0) ? MS_W'(1) : in_period_ms;
    push_cmd.idx      = in_slot_index;
    push_cmd.in_range = ({1'b0, in_slot_index} < (SLOT_W + 1)'(EFF_SLOTS));
    push_cmd.arm      = in_arm_notify;
  end

endmodule

// File: design/otsb_queue.sv
// Command queue: short FIFO decoupling the front end from the back end.
module otsb_queue import otsb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  output logic    full,
  input  logic    pop,
  output q_head_t head
);

  cmd_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;

  assign full       = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: design/otsb_back.sv
// Back end: slot state, command execution, tick countdown and result register.
module otsb_back import otsb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_head_t head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    out_res
);

  logic                 act_r [EFF_SLOTS];
  logic                 act_nxt [EFF_SLOTS];
  logic [MS_W-1:0]      rem_r [EFF_SLOTS];
  logic [MS_W-1:0]      rem_nxt [EFF_SLOTS];
  logic                 ntf_r [EFF_SLOTS];
  logic                 ntf_nxt [EFF_SLOTS];
  logic [EFF_SLOTS-1:0] exp_mask_r, exp_mask_nxt;
  bk_state_t            state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_r, out_nxt;

  logic                 out_free;
  logic                 found;
  logic [SLOT_W-1:0]    pick;
  logic [EFF_SLOTS-1:0] mask_left;
  logic                 q_run;
  logic [MS_W-1:0]      q_rem;

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign out_free  = !out_valid_r || out_ready;

  // Sequencer: run one command, or walk the expiry mask one result per unstalled cycle
  always_comb begin
    state_nxt     = state_r;
    exp_mask_nxt  = exp_mask_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    pop           = 1'b0;
    found         = 1'b0;
    pick          = '0;
    mask_left     = exp_mask_r;
    q_run         = 1'b0;
    q_rem         = '0;
    for (int i = 0; i < EFF_SLOTS; i++) begin
      act_nxt[i] = act_r[i];
      rem_nxt[i] = rem_r[i];
      ntf_nxt[i] = ntf_r[i];
    end

    case (state_r)
      BK_RUN: begin
        if (head.valid && head.cmd.op == OP_TICK) begin
          // Tick: count every active slot down, collect notified expiries
          pop = 1'b1;
          for (int i = 0; i < EFF_SLOTS; i++) begin
            exp_mask_nxt[i] = 1'b0;
            if (act_r[i]) begin
              if (rem_r[i] <= MS_W'(1)) begin
                rem_nxt[i]      = '0;
                act_nxt[i]      = 1'b0;
                ntf_nxt[i]      = 1'b0;
                exp_mask_nxt[i] = ntf_r[i];
              end else begin
                rem_nxt[i] = rem_r[i] - 1'b1;
              end
            end
          end
          if (exp_mask_nxt != '0) begin
            state_nxt = BK_EMIT;
          end
        end else if (head.valid && out_free) begin
          pop                   = 1'b1;
          out_valid_nxt         = 1'b1;
          out_nxt.slot          = head.cmd.idx;
          out_nxt.remaining     = '0;
          out_nxt.running       = 1'b0;
          out_nxt.last          = 1'b1;
          case (head.cmd.op)
            OP_START: begin
              // Lowest inactive slot wins
              for (int i = 0; i < EFF_SLOTS; i++) begin
                if (!act_r[i] && !found) begin
                  found = 1'b1;
                  pick  = SLOT_W'(i);
                end
              end
              if (found) begin
                for (int i = 0; i < EFF_SLOTS; i++) begin
                  if (pick == SLOT_W'(i)) begin
                    act_nxt[i] = 1'b1;
                    rem_nxt[i] = head.cmd.period;
                    ntf_nxt[i] = head.cmd.arm;
                  end
                end
                out_nxt.kind = K_STARTED;
                out_nxt.slot = pick;
              end else begin
                out_nxt.kind = K_FULL;
                out_nxt.slot = '0;
              end
            end
            OP_CANCEL: begin
              for (int i = 0; i < EFF_SLOTS; i++) begin
                if (head.cmd.in_range && head.cmd.idx == SLOT_W'(i)) begin
                  act_nxt[i] = 1'b0;
                  rem_nxt[i] = '0;
                  ntf_nxt[i] = 1'b0;
                end
              end
              out_nxt.kind = K_CANCELLED;
            end
            default: begin
              // Query: inactive or absent slot reads as stopped
              for (int i = 0; i < EFF_SLOTS; i++) begin
                if (head.cmd.in_range && head.cmd.idx == SLOT_W'(i) && act_r[i]) begin
                  q_run = 1'b1;
                  q_rem = rem_r[i];
                end
              end
              out_nxt.kind      = K_QUERY;
              out_nxt.remaining = q_rem;
              out_nxt.running   = q_run;
            end
          endcase
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          for (int i = 0; i < EFF_SLOTS; i++) begin
            if (exp_mask_r[i] && !found) begin
              found = 1'b1;
              pick  = SLOT_W'(i);
            end
          end
          mask_left         = exp_mask_r & (exp_mask_r - 1'b1);
          exp_mask_nxt      = mask_left;
          out_valid_nxt     = 1'b1;
          out_nxt.kind      = K_EXPIRED;
          out_nxt.slot      = pick;
          out_nxt.remaining = '0;
          out_nxt.running   = 1'b0;
          out_nxt.last      = (mask_left == '0);
          if (mask_left == '0) begin
            state_nxt = BK_RUN;
          end
        end
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase
  end

  // Control and slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      out_valid_r <= 1'b0;
      exp_mask_r  <= '0;
      for (int i = 0; i < EFF_SLOTS; i++) begin
        act_r[i] <= 1'b0;
        rem_r[i] <= '0;
        ntf_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      exp_mask_r  <= exp_mask_nxt;
      for (int i = 0; i < EFF_SLOTS; i++) begin
        act_r[i] <= act_nxt[i];
        rem_r[i] <= rem_nxt[i];
        ntf_r[i] <= ntf_nxt[i];
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// File: design/otsb_checker.sv
// Checker: port-level properties of the timer slot bank, bound to the top level.
module otsb_checker import otsb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic [SLOT_W-1:0] out_slot_number,
  input logic [MS_W-1:0]   out_remaining_ms,
  input logic              out_is_running,
  input logic              out_last_of_run
);

  // A waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // Only a query reply carries time or running flag
  a_query_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_QUERY |-> out_remaining_ms == '0 && !out_is_running)
    else $error("time field set outside a query reply");

  // Single-result requests always close their run
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_EXPIRED |-> out_last_of_run)
    else $error("single result without last flag");

  // A full-bank answer names slot zero
  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_FULL |-> out_slot_number == '0)
    else $error("no-free-slot result with a slot number");

endmodule

bind one_shot_timer_slot_bank_top otsb_checker u_otsb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_kind         (out_chan.kind),
  .out_slot_number  (out_chan.slot_number),
  .out_remaining_ms (out_chan.remaining_ms),
  .out_is_running   (out_chan.is_running),
  .out_last_of_run  (out_chan.last_of_run)
);
